### src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator package
// Shared widths, codes and types for the pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int DEFAULT_NUM_BLOCKS = 256;

    localparam int BLOCK_SIZE_W = 11;
    localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RESET = 11'd8;

    localparam int IDX_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 18;
    localparam int COUNT_W   = 9;
    localparam int BYTES_W   = 19;

    localparam int S_TDATA_W   = 8;
    localparam int M_FIELDS_W  = IDX_W + OFFSET_W + 2 * COUNT_W + 2 * BYTES_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - M_FIELDS_W;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NONE_USED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTRL_INIT,
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

endpackage

### src/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// Next-link memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module fbpa_link_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Pool allocator controller
// Sweeps the link memory after reset, then pops the free list by reading a
// link and pushes it by writing one, holding the result register.
// ----------------------------------------------------------------------------
module fbpa_ctrl #(
    parameter  int NUM_BLOCKS = fbpa_pkg::DEFAULT_NUM_BLOCKS,
    localparam int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic                              req_action,
    input  logic [fbpa_pkg::IDX_W-1:0]        req_index,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output fbpa_pkg::status_t                 rsp_status,
    output logic [ADDR_W-1:0]                 rsp_index,
    output logic [CNT_W-1:0]                  rsp_used,
    input  logic                              cfg_we,
    input  logic [fbpa_pkg::BLOCK_SIZE_W-1:0] cfg_wdata,
    output logic [fbpa_pkg::BLOCK_SIZE_W-1:0] block_size,
    output logic                              ram_wr_en,
    output logic [ADDR_W-1:0]                 ram_wr_addr,
    output logic [CNT_W-1:0]                  ram_wr_data,
    output logic [ADDR_W-1:0]                 ram_rd_addr,
    input  logic [CNT_W-1:0]                  ram_rd_data
);

    import fbpa_pkg::*;

    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BLOCKS - 1);
    localparam logic [CNT_W-1:0]  END_MARK  = CNT_W'(NUM_BLOCKS);

    ctrl_state_t              state_reg, state_next;
    logic [ADDR_W-1:0]        init_addr_reg, init_addr_next;
    logic [CNT_W-1:0]         head_reg, head_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [BLOCK_SIZE_W-1:0]  block_size_reg, block_size_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     act_reg, act_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    status_t                  out_status_reg, out_status_next;
    logic [ADDR_W-1:0]        out_index_reg, out_index_next;
    logic [CNT_W-1:0]         out_used_reg, out_used_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CTRL_INIT;
            init_addr_reg  <= '0;
            head_reg       <= '0;
            used_reg       <= '0;
            block_size_reg <= BLOCK_SIZE_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_addr_reg  <= init_addr_next;
            head_reg       <= head_next;
            used_reg       <= used_next;
            block_size_reg <= block_size_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_used_reg   <= out_used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        init_addr_next  = init_addr_reg;
        head_next       = head_reg;
        used_next       = used_reg;
        block_size_next = cfg_we ? cfg_wdata : block_size_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        act_next        = act_reg;
        idx_next        = idx_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_used_next   = out_used_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        req_ready       = 1'b0;

        unique case (state_reg)
            CTRL_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = init_addr_reg;
                ram_wr_data = CNT_W'(init_addr_reg) + CNT_W'(1);
                if (init_addr_reg == LAST_ADDR)
                begin
                    state_next = CTRL_IDLE;
                end
                else
                begin
                    init_addr_next = init_addr_reg + ADDR_W'(1);
                end
            end
            CTRL_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    act_next   = req_action;
                    idx_next   = req_index;
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_index_next  = '0;
                    state_next      = CTRL_IDLE;
                    if (act_reg == ACT_ALLOC)
                    begin
                        if (used_reg >= END_MARK || head_reg >= END_MARK)
                        begin
                            out_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            out_index_next = ADDR_W'(head_reg);
                            head_next      = ram_rd_data;
                            used_next      = used_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (used_reg == '0 || CMP_W'(idx_reg) >= CMP_W'(NUM_BLOCKS))
                        begin
                            out_status_next = ST_NONE_USED;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = ADDR_W'(idx_reg);
                            ram_wr_data = head_reg;
                            head_next   = CNT_W'(idx_reg);
                            used_next   = used_reg - CNT_W'(1);
                        end
                    end
                    out_used_next = used_next;
                end
            end
        endcase
    end

    assign ram_rd_addr = ADDR_W'(head_reg);
    assign rsp_valid   = out_valid_reg;
    assign rsp_status  = out_status_reg;
    assign rsp_index   = out_index_reg;
    assign rsp_used    = out_used_reg;
    assign block_size  = block_size_reg;

endmodule

### src/fbpa_resp.sv
// ----------------------------------------------------------------------------
// Pool allocator result formatter
// Derives offset, block and byte counts from the held result and packs them.
// ----------------------------------------------------------------------------
module fbpa_resp #(
    parameter  int NUM_BLOCKS = fbpa_pkg::DEFAULT_NUM_BLOCKS,
    localparam int ADDR_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1)
) (
    input  fbpa_pkg::status_t                 rsp_status,
    input  logic [ADDR_W-1:0]                 rsp_index,
    input  logic [CNT_W-1:0]                  rsp_used,
    input  logic [fbpa_pkg::BLOCK_SIZE_W-1:0] block_size,
    output logic [fbpa_pkg::M_TDATA_W-1:0]    tdata,
    output logic [fbpa_pkg::STATUS_W-1:0]     tuser
);

    import fbpa_pkg::*;

    logic [CNT_W-1:0]    free_count;
    logic [OFFSET_W-1:0] offset;
    logic [BYTES_W-1:0]  used_bytes;
    logic [BYTES_W-1:0]  spare_bytes;

    always_comb
    begin
        free_count  = CNT_W'(NUM_BLOCKS) - rsp_used;
        offset      = OFFSET_W'(rsp_index) * OFFSET_W'(block_size);
        used_bytes  = BYTES_W'(rsp_used) * BYTES_W'(block_size);
        spare_bytes = BYTES_W'(free_count) * BYTES_W'(block_size);
        tdata = {{M_PAD_W{1'b0}}, spare_bytes, used_bytes, COUNT_W'(rsp_used),
                 COUNT_W'(free_count), offset, IDX_W'(rsp_index)};
        tuser = rsp_status;
    end

endmodule

### src/fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// LIFO free list of equal-size blocks kept in a next-link memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the link memory, writing each entry to point
// at the next block, and takes no request until the sweep is done; block_size
// writes are taken throughout. A request is accepted in the idle state, while
// the registered-read link memory fetches the link of the free-list head;
// the execute state then pops the head (allocate) or writes the freed
// block's link and pushes it (free), and loads the result register, waiting
// while an earlier result is still held on the output. Allocating from an
// empty pool or freeing with nothing allocated (or an index beyond the pool)
// is refused with a status code and changes nothing.
module fixed_block_pool_allocator_top #(
    parameter int NUM_BLOCKS = fbpa_pkg::DEFAULT_NUM_BLOCKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbpa_pkg::S_TDATA_W-1:0]    s_tdata,   // block_index[7:0]
    input  logic [0:0]                        s_tuser,   // action[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // granted_index[7:0], granted_offset[25:8], free_blocks[34:26],
    // used_blocks[43:35], used_bytes[62:44], spare_bytes[81:63], zeros above
    output logic [fbpa_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [fbpa_pkg::STATUS_W-1:0]     m_tuser,   // status[1:0]
    input  logic                              cfg_we,
    input  logic [fbpa_pkg::BLOCK_SIZE_W-1:0] cfg_wdata
);

    import fbpa_pkg::*;

    localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

    status_t             rsp_status;
    logic [ADDR_W-1:0]   rsp_index;
    logic [CNT_W-1:0]    rsp_used;
    logic [BLOCK_SIZE_W-1:0] block_size;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [CNT_W-1:0]    ram_wr_data;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [CNT_W-1:0]    ram_rd_data;

    fbpa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_action  (s_tuser[0]),
        .req_index   (s_tdata[IDX_W-1:0]),
        .rsp_valid   (m_tvalid),
        .rsp_ready   (m_tready),
        .rsp_status  (rsp_status),
        .rsp_index   (rsp_index),
        .rsp_used    (rsp_used),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .block_size  (block_size),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    fbpa_link_ram #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (ADDR_W),
        .DATA_W (CNT_W)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fbpa_resp #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_resp (
        .rsp_status (rsp_status),
        .rsp_index  (rsp_index),
        .rsp_used   (rsp_used),
        .block_size (block_size),
        .tdata      (m_tdata),
        .tuser      (m_tuser)
    );

endmodule

### tb/sv/tb_fixed_block_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// Fixed block pool allocator testbench
// Drives allocate and free requests with random idling on both streams and
// predicts each result from a local model of the free list, the counts and
// the block size, or takes it from a short table of directed requests that
// opens the run. Then runs phases of random, mostly well-formed traffic over
// several block sizes, including a full fill and drain of the pool.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator_top;

    import fbpa_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int POOL_BLOCKS = DEFAULT_NUM_BLOCKS;
    localparam int RUN_LIMIT   = 4000000;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    granted_index;
        logic [OFFSET_W-1:0] granted_offset;
        logic [COUNT_W-1:0]  free_blocks;
        logic [COUNT_W-1:0]  used_blocks;
        logic [BYTES_W-1:0]  used_bytes;
        logic [BYTES_W-1:0]  spare_bytes;
    } pool_result_t;

    typedef struct {
        logic             act;
        logic [IDX_W-1:0] idx;
        bit               typed;
        pool_result_t     res;
    } request_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    cfg_we;
    logic [BLOCK_SIZE_W-1:0] cfg_wdata;

    logic [COUNT_W-1:0]      next_block [POOL_BLOCKS];
    logic [COUNT_W-1:0]      list_head;
    logic [COUNT_W-1:0]      blocks_used;
    logic [BLOCK_SIZE_W-1:0] block_size;

    pool_result_t     pending_results [$];
    request_row_t     request_table [$];
    logic [IDX_W-1:0] held_blocks [$];
    int               fail_count;
    int               idle_pct;
    int               stall_pct;

    fixed_block_pool_allocator_top #(
        .NUM_BLOCKS(POOL_BLOCKS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic pool_result_t pool_apply(input logic act,
                                                input logic [IDX_W-1:0] idx);
        pool_result_t r;
        logic [31:0]  byte_used;
        logic [31:0]  byte_total;
        r = '0;
        r.status = ST_OK;
        if (act == ACT_ALLOC)
        begin
            if (blocks_used >= POOL_BLOCKS || list_head >= POOL_BLOCKS)
                r.status = ST_EMPTY;
            else
            begin
                r.granted_index = list_head[IDX_W-1:0];
                byte_used = 32'(list_head) * 32'(block_size);
                r.granted_offset = byte_used[OFFSET_W-1:0];
                list_head = next_block[list_head[IDX_W-1:0]];
                blocks_used = blocks_used + COUNT_W'(1);
            end
        end
        else if (blocks_used == 0 || idx >= POOL_BLOCKS)
            r.status = ST_NONE_USED;
        else
        begin
            next_block[idx] = list_head;
            list_head = {1'b0, idx};
            blocks_used = blocks_used - COUNT_W'(1);
        end
        byte_used  = 32'(blocks_used) * 32'(block_size);
        byte_total = 32'(POOL_BLOCKS) * 32'(block_size);
        r.free_blocks = COUNT_W'(POOL_BLOCKS) - blocks_used;
        r.used_blocks = blocks_used;
        r.used_bytes  = byte_used[BYTES_W-1:0];
        r.spare_bytes = BYTES_W'(byte_total - byte_used);
        return r;
    endfunction

    task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
                                input bit typed, input pool_result_t typed_res,
                                output pool_result_t outcome);
        if ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= idx;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        outcome = pool_apply(act, idx);
        pending_results.push_back(typed ? typed_res : outcome);
    endtask

    task automatic add_row(input logic act, input logic [IDX_W-1:0] idx,
                           input bit typed, input status_t st, input int gidx,
                           input int goff, input int nfree, input int nused,
                           input int bused, input int bspare);
        request_row_t row;
        row.act = act;
        row.idx = idx;
        row.typed = typed;
        row.res.status = st;
        row.res.granted_index = IDX_W'(gidx);
        row.res.granted_offset = OFFSET_W'(goff);
        row.res.free_blocks = COUNT_W'(nfree);
        row.res.used_blocks = COUNT_W'(nused);
        row.res.used_bytes = BYTES_W'(bused);
        row.res.spare_bytes = BYTES_W'(bspare);
        request_table.push_back(row);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_block_size(input logic [BLOCK_SIZE_W-1:0] value);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        block_size = value;
        cfg_we <= 1'b0;
    endtask

    task automatic run_mix(input int count, input int alloc_pct, input int noise_pct);
        pool_result_t     outcome;
        logic             act;
        logic [IDX_W-1:0] idx;
        bit               from_held;
        int               pos;
        for (int n = 0; n < count; n++)
        begin
            act = ($urandom_range(99) < alloc_pct) ? ACT_ALLOC : ACT_FREE;
            from_held = 1'b0;
            idx = IDX_W'($urandom_range(255));
            if (act == ACT_FREE && held_blocks.size() != 0
                && $urandom_range(99) >= noise_pct)
            begin
                pos = int'($urandom_range(held_blocks.size() - 1));
                idx = held_blocks[pos];
                held_blocks.delete(pos);
                from_held = 1'b1;
            end
            send_request(act, idx, 1'b0, '0, outcome);
            if (outcome.status == ST_OK)
            begin
                if (act == ACT_ALLOC)
                    held_blocks.push_back(outcome.granted_index);
                else if (!from_held)
                begin
                    for (int k = 0; k < held_blocks.size(); k++)
                        if (held_blocks[k] == idx)
                        begin
                            held_blocks.delete(k);
                            break;
                        end
                end
            end
        end
    endtask

    task automatic run_phase(input logic [BLOCK_SIZE_W-1:0] size, input int count);
        write_block_size(size);
        run_mix(count / 2, 70, 8);
        run_mix(count - count / 2, 30, 8);
    endtask

    // check each result against the oldest prediction
    always @(posedge clk)
    begin
        pool_result_t got;
        pool_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status         = status_t'(m_tuser);
            got.granted_index  = m_tdata[7:0];
            got.granted_offset = m_tdata[25:8];
            got.free_blocks    = m_tdata[34:26];
            got.used_blocks    = m_tdata[43:35];
            got.used_bytes     = m_tdata[62:44];
            got.spare_bytes    = m_tdata[81:63];
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d index %0d used %0d",
                             got.status, got.granted_index, got.used_blocks);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("mismatch: status %0d/%0d index %0d/%0d offset %0d/%0d",
                                 want.status, got.status, want.granted_index,
                                 got.granted_index, want.granted_offset,
                                 got.granted_offset);
                        $display("  free %0d/%0d used %0d/%0d bytes %0d/%0d spare %0d/%0d",
                                 want.free_blocks, got.free_blocks, want.used_blocks,
                                 got.used_blocks, want.used_bytes, got.used_bytes,
                                 want.spare_bytes, got.spare_bytes);
                    end
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #RUN_LIMIT;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        pool_result_t outcome;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        fail_count = 0;
        idle_pct   = 29;
        stall_pct  = 29;
        for (int i = 0; i < POOL_BLOCKS; i++)
            next_block[i] = COUNT_W'(i + 1);
        list_head   = '0;
        blocks_used = '0;
        block_size  = BLOCK_SIZE_RESET;

        add_row(ACT_FREE,  8'd0,   1'b1, ST_NONE_USED, 0, 0, 256, 0, 0, 2048);
        add_row(ACT_ALLOC, 8'd0,   1'b1, ST_OK, 0, 0, 255, 1, 8, 2040);
        add_row(ACT_ALLOC, 8'd0,   1'b1, ST_OK, 1, 8, 254, 2, 16, 2032);
        add_row(ACT_FREE,  8'd1,   1'b1, ST_OK, 0, 0, 255, 1, 8, 2040);
        add_row(ACT_ALLOC, 8'd255, 1'b1, ST_OK, 1, 8, 254, 2, 16, 2032);
        add_row(ACT_FREE,  8'd255, 1'b1, ST_OK, 0, 0, 255, 1, 8, 2040);
        add_row(ACT_ALLOC, 8'd0,   1'b1, ST_OK, 255, 2040, 254, 2, 16, 2032);
        add_row(ACT_ALLOC, 8'd0,   1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FREE,  8'd0,   1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FREE,  8'd0,   1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FREE,  8'd170, 1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FREE,  8'd85,  1'b1, ST_NONE_USED, 0, 0, 256, 0, 0, 2048);
        add_row(ACT_ALLOC, 8'd255, 1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_ALLOC, 8'd0,   1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_FREE,  8'd255, 1'b0, ST_OK, 0, 0, 0, 0, 0, 0);
        add_row(ACT_ALLOC, 8'd0,   1'b0, ST_OK, 0, 0, 0, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (request_table[i])
            send_request(request_table[i].act, request_table[i].idx,
                         request_table[i].typed, request_table[i].res, outcome);

        run_phase(11'd1, 200);
        // hold both streams open for a whole phase
        idle_pct  = 0;
        stall_pct = 0;
        run_phase(11'd1024, 200);
        idle_pct  = 29;
        stall_pct = 29;
        run_phase(11'd0, 200);

        // fill past empty, then drain past nothing allocated
        write_block_size(11'd2047);
        run_mix(262, 100, 0);
        run_mix(270, 0, 0);

        run_phase(BLOCK_SIZE_W'($urandom_range(1024, 1)), 200);
        run_phase(BLOCK_SIZE_W'($urandom_range(2047)), 200);

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### fixed_block_pool_allocator_top.f
src/fbpa_pkg.sv
src/fbpa_link_ram.sv
src/fbpa_ctrl.sv
src/fbpa_resp.sv
src/fixed_block_pool_allocator_top.sv
tb/sv/tb_fixed_block_pool_allocator_top.sv
